>>> hw/rtl/dst_pkg.sv
// Shared types, sizes and codes for the descriptor slot table.
package dst_pkg;

   // Table size and field widths
   localparam int SLOTS  = 16;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CMD_W  = 3;
   localparam int FD_W   = 10;
   localparam int SLOT_W = 6;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 5;

   // Slot limit, one bit wider than a slot field so that 64 fits
   localparam logic [SLOT_W:0] SLOTS_LIM = (SLOT_W + 1)'(SLOTS);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INSTALL = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DUP     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DUP2    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_GET     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLOSE   = 3'd4;

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE  = 2'd1;
   localparam logic [STAT_W-1:0] ST_UNUSED = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture request, read the value memory at slot_a
      logic exec;   // evaluate, update the table, load the response register
   } ctl_type;

endpackage

>>> hw/rtl/dst_controller.sv
// Sequencing state machine and response-valid register for the slot table.
module dst_controller import dst_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output ctl_type ctl
);

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_EXEC = 1'b1;

   logic [0:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      ctl.load     = req_tvalid && (state_ff == S_IDLE);
      // execute only when the response register is free or drains now
      ctl.exec     = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (ctl.load) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (ctl.exec) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/dst_datapath.sv
// Slot table storage, lowest-free search, command evaluation and response register.
module dst_datapath import dst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctl_type           ctl,
   input  logic [CMD_W-1:0]  command,
   input  logic [FD_W-1:0]   desc_num,
   input  logic [SLOT_W-1:0] slot_a,
   input  logic [SLOT_W-1:0] slot_b,
   output logic [STAT_W-1:0] status,
   output logic [SLOT_W-1:0] slot_out,
   output logic [FD_W-1:0]   global_out,
   output logic [CNT_W-1:0]  open_slots
);

   // Captured request
   logic [CMD_W-1:0]  cmd_ff;
   logic [FD_W-1:0]   gfd_ff;
   logic [SLOT_W-1:0] a_ff, b_ff;
   logic [FD_W-1:0]   rd_data_ff;

   // Table state
   logic [FD_W-1:0]   value_mem [SLOTS];
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Response register
   logic [STAT_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0] slot_out_ff, slot_out_in;
   logic [FD_W-1:0]   global_out_ff, global_out_in;

   // Evaluation
   logic              a_ok, b_ok, a_used, b_used, free_found;
   logic [IDX_W-1:0]  a_idx, b_idx, free_idx, wr_idx;
   logic              wr_en;
   logic [FD_W-1:0]   wr_data;

   assign a_idx = a_ff[IDX_W-1:0];
   assign b_idx = b_ff[IDX_W-1:0];
   assign a_ok  = ({1'b0, a_ff} < SLOTS_LIM);
   assign b_ok  = ({1'b0, b_ff} < SLOTS_LIM);
   assign a_used = a_ok && valid_ff[a_idx];
   assign b_used = b_ok && valid_ff[b_idx];

   // Lowest unused slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      status_in     = ST_OK;
      slot_out_in   = '0;
      global_out_in = '0;
      valid_in      = valid_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_idx        = free_idx;
      wr_data       = rd_data_ff;
      case (cmd_ff)
         CMD_INSTALL: begin
            if (!free_found) begin
               status_in = ST_FULL;
            end else begin
               wr_en              = 1'b1;
               wr_data            = gfd_ff;
               valid_in[free_idx] = 1'b1;
               count_in           = count_ff + 1'b1;
               slot_out_in        = SLOT_W'(free_idx);
            end
         end
         CMD_DUP: begin
            if (!a_ok) begin
               status_in = ST_RANGE;
            end else if (!a_used) begin
               status_in = ST_UNUSED;
            end else if (!free_found) begin
               status_in = ST_FULL;
            end else begin
               wr_en              = 1'b1;
               valid_in[free_idx] = 1'b1;
               count_in           = count_ff + 1'b1;
               slot_out_in        = SLOT_W'(free_idx);
            end
         end
         CMD_DUP2: begin
            if (!a_ok || !b_ok) begin
               status_in = ST_RANGE;
            end else if (!a_used) begin
               status_in = ST_UNUSED;
            end else begin
               // onto itself: report success, leave the table alone
               if (a_ff != b_ff) begin
                  wr_en           = 1'b1;
                  wr_idx          = b_idx;
                  valid_in[b_idx] = 1'b1;
                  if (!b_used) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               slot_out_in = b_ff;
            end
         end
         CMD_GET: begin
            if (!a_ok) begin
               status_in = ST_RANGE;
            end else if (!a_used) begin
               status_in = ST_UNUSED;
            end else begin
               global_out_in = rd_data_ff;
            end
         end
         CMD_CLOSE: begin
            if (!a_ok) begin
               status_in = ST_RANGE;
            end else if (!a_used) begin
               status_in = ST_UNUSED;
            end else begin
               valid_in[a_idx] = 1'b0;
               count_in        = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Request capture and registered memory read
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff     <= command;
         gfd_ff     <= desc_num;
         a_ff       <= slot_a;
         b_ff       <= slot_b;
         rd_data_ff <= value_mem[slot_a[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec && wr_en) begin
         value_mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (ctl.exec) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         status_ff     <= status_in;
         slot_out_ff   <= slot_out_in;
         global_out_ff <= global_out_in;
      end
   end

   assign status     = status_ff;
   assign slot_out   = slot_out_ff;
   assign global_out = global_out_ff;
   assign open_slots = count_ff;

endmodule

>>> hw/rtl/descriptor_slot_table.sv
// Top level of the descriptor slot table: controller, datapath and stream ports.
//
//   channel | direction | tdata fields (lowest bit first)
//   --------+-----------+----------------------------------------------------
//   req_    | in        | command[2:0] desc_num[12:3] slot_a[18:13] slot_b[24:19]
//   rsp_    | out       | status[1:0] slot_out[7:2] global_out[17:8] open_slots[22:18]
//
// A request is first captured in the idle state, which also reads the value memory
// at slot_a; the execute state then runs the lowest-free search, updates the table
// and loads the response register. A new request is taken only once the block is
// back in the idle state, so requests never overlap.
// Reset clears the valid bits and the open count at once; no clearing pass.
// A stalled response holds the execute state until the response register drains.
module descriptor_slot_table import dst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // command, desc_num, slot_a, slot_b, zero fill
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // status, slot_out, global_out, open_slots, zero fill
);

   ctl_type           ctl;
   logic [STAT_W-1:0] status;
   logic [SLOT_W-1:0] slot_out;
   logic [FD_W-1:0]   global_out;
   logic [CNT_W-1:0]  open_slots;

   // Sequence each request: capture, then execute when the response slot frees
   dst_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   // Unpack the request fields straight into the datapath
   dst_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .command    (req_tdata[2:0]),
      .desc_num   (req_tdata[12:3]),
      .slot_a     (req_tdata[18:13]),
      .slot_b     (req_tdata[24:19]),
      .status     (status),
      .slot_out   (slot_out),
      .global_out (global_out),
      .open_slots (open_slots)
   );

   // Pack the response; bit 23 is fill
   assign rsp_tdata = {1'b0, open_slots, global_out, slot_out, status};

`ifndef ASSERT_OFF
   // An accepted request blocks the next one while it executes
   a_one_per_two: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken in the cycle after an accepted request");

   // A failed command reports no slot and no descriptor
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status != ST_OK) |-> (slot_out == '0) && (global_out == '0))
      else $error("failed response carries a slot or descriptor");

   // A reported slot lies inside the table
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, slot_out} < SLOTS_LIM))
      else $error("response slot outside the table");
`endif

endmodule

>>> sim/tb.sv
// Self-checking testbench for the descriptor slot table stream block.
module tb;
   import dst_pkg::*;

   // Command codes the block leaves undefined; they must change nothing
   localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

   localparam int STALL_LIMIT = 3000;   // cycles without any handshake
   localparam int DRAIN_CYCLES = 8;     // settle time after the last response
   localparam int MAX_REPORTS = 10;

   // Request and response layouts, lowest field in the lowest bits
   typedef struct packed {
      logic [SLOT_W-1:0] slot_b;
      logic [SLOT_W-1:0] slot_a;
      logic [FD_W-1:0]   desc_num;
      logic [CMD_W-1:0]  command;
   } fd_request_type;

   typedef struct packed {
      logic [CNT_W-1:0]  open_slots;
      logic [FD_W-1:0]   global_out;
      logic [SLOT_W-1:0] slot_out;
      logic [STAT_W-1:0] status;
   } fd_response_type;

   typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} traffic_mode_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // command, desc_num, slot_a, slot_b, zero fill
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // status, slot_out, global_out, open_slots, zero fill

   // Shadow copy of the descriptor table, advanced on every accepted request
   logic             shadow_valid [SLOTS];
   logic [FD_W-1:0]  shadow_value [SLOTS];
   logic [CNT_W-1:0] shadow_count;

   fd_response_type pending_responses[$];
   fd_response_type got_rsp;
   fd_response_type want_rsp;

   int mismatch_count;
   int idle_cycles;
   int send_idle_pct;
   int stall_pct;
   int requests_sent;
   int responses_seen;
   int status_hits [4];
   int command_hits [8];
   int full_table_hits;

   descriptor_slot_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Lowest unused slot in the shadow table, or SLOTS when every slot is taken
   function automatic int lowest_free_slot();
      for (int i = 0; i < SLOTS; i++) begin
         if (!shadow_valid[i]) return i;
      end
      return SLOTS;
   endfunction

   // Advance the shadow table by one request and return the response it must give.
   // Any failing check leaves the table and the count untouched.
   function automatic fd_response_type apply_table_command(fd_request_type r);
      fd_response_type res;
      int free_idx;
      int a;
      int b;
      res = '0;
      a = r.slot_a;
      b = r.slot_b;
      free_idx = lowest_free_slot();
      case (r.command)
         CMD_INSTALL: begin
            if (free_idx >= SLOTS) begin
               res.status = ST_FULL;
            end else begin
               shadow_valid[free_idx] = 1'b1;
               shadow_value[free_idx] = r.desc_num;
               shadow_count++;
               res.slot_out = SLOT_W'(free_idx);
            end
         end
         CMD_DUP: begin
            // range, then occupancy of the source, then room in the table
            if (a >= SLOTS) begin
               res.status = ST_RANGE;
            end else if (!shadow_valid[a]) begin
               res.status = ST_UNUSED;
            end else if (free_idx >= SLOTS) begin
               res.status = ST_FULL;
            end else begin
               shadow_valid[free_idx] = 1'b1;
               shadow_value[free_idx] = shadow_value[a];
               shadow_count++;
               res.slot_out = SLOT_W'(free_idx);
            end
         end
         CMD_DUP2: begin
            // both indexes are range-checked before the source is looked at
            if (a >= SLOTS || b >= SLOTS) begin
               res.status = ST_RANGE;
            end else if (!shadow_valid[a]) begin
               res.status = ST_UNUSED;
            end else begin
               if (a != b) begin
                  if (!shadow_valid[b]) shadow_count++;
                  shadow_valid[b] = 1'b1;
                  shadow_value[b] = shadow_value[a];
               end
               res.slot_out = r.slot_b;
            end
         end
         CMD_GET: begin
            if (a >= SLOTS) begin
               res.status = ST_RANGE;
            end else if (!shadow_valid[a]) begin
               res.status = ST_UNUSED;
            end else begin
               res.global_out = shadow_value[a];
            end
         end
         CMD_CLOSE: begin
            if (a >= SLOTS) begin
               res.status = ST_RANGE;
            end else if (!shadow_valid[a]) begin
               res.status = ST_UNUSED;
            end else begin
               shadow_valid[a] = 1'b0;
               shadow_value[a] = '0;
               shadow_count--;
            end
         end
         default: begin
            // reserved codes: report the count, touch nothing
         end
      endcase
      res.open_slots = shadow_count;
      return res;
   endfunction

   // Pick a slot index: mostly an occupied one, sometimes any in range,
   // now and then an out-of-range one from SLOTS to 63
   function automatic logic [SLOT_W-1:0] pick_slot();
      int roll;
      int occupied;
      int nth;
      roll = $urandom_range(0, 99);
      occupied = 0;
      for (int i = 0; i < SLOTS; i++) occupied += shadow_valid[i];
      if (roll < 8) return SLOT_W'($urandom_range(SLOTS, 63));
      if (roll < 62 && occupied > 0) begin
         nth = $urandom_range(0, occupied - 1);
         for (int i = 0; i < SLOTS; i++) begin
            if (shadow_valid[i]) begin
               if (nth == 0) return SLOT_W'(i);
               nth--;
            end
         end
      end
      return SLOT_W'($urandom_range(0, SLOTS - 1));
   endfunction

   // Drive one request, hold it until accepted, then record its expected response.
   // Valid stays high after acceptance so back-to-back requests need no toggle.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [FD_W-1:0] gfd,
                               input logic [SLOT_W-1:0] a, input logic [SLOT_W-1:0] b);
      fd_request_type r;
      fd_response_type res;
      r.command = cmd;
      r.desc_num = gfd;
      r.slot_a = a;
      r.slot_b = b;
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (lowest_free_slot() >= SLOTS && (cmd == CMD_INSTALL || cmd == CMD_DUP))
         full_table_hits++;
      res = apply_table_command(r);
      pending_responses.push_back(res);
      requests_sent++;
      command_hits[cmd]++;
      status_hits[res.status]++;
   endtask

   task automatic note_mismatch(input string field, input int want_v, input int got_v);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("[%0t] response %0d: %s expected %0d, got %0d",
                  $time, responses_seen, field, want_v, got_v);
   endtask

   // Receiver: stall at random and check each response against the oldest expectation
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp = fd_response_type'(rsp_tdata[22:0]);
         responses_seen++;
         if (pending_responses.size() == 0) begin
            note_mismatch("unexpected response, outstanding count", 0, 1);
         end else begin
            want_rsp = pending_responses.pop_front();
            if (got_rsp.status !== want_rsp.status)
               note_mismatch("status", want_rsp.status, got_rsp.status);
            if (got_rsp.slot_out !== want_rsp.slot_out)
               note_mismatch("slot_out", want_rsp.slot_out, got_rsp.slot_out);
            if (got_rsp.global_out !== want_rsp.global_out)
               note_mismatch("global_out", want_rsp.global_out, got_rsp.global_out);
            if (got_rsp.open_slots !== want_rsp.open_slots)
               note_mismatch("open_slots", want_rsp.open_slots, got_rsp.open_slots);
         end
      end
   end

   // Watchdog: give up once neither channel has moved for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, pending_responses.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Basic successful paths, with field extremes on the installed values
   task automatic test_basic_commands();
      send_request(CMD_INSTALL, 10'd1023, 6'd63, 6'd63);   // lands in slot 0
      send_request(CMD_INSTALL, 10'd0, 6'd0, 6'd0);         // lands in slot 1
      send_request(CMD_GET, 10'd0, 6'd0, 6'd0);
      send_request(CMD_GET, 10'd1023, 6'd1, 6'd63);
      send_request(CMD_DUP, 10'($urandom), 6'd0, 6'($urandom));
      // dup2 onto itself is a successful no-op
      send_request(CMD_DUP2, 10'($urandom), 6'd0, 6'd0);
      // dup2 onto an unused slot at the top of the table grows the count
      send_request(CMD_DUP2, 10'($urandom), 6'd1, 6'(SLOTS - 1));
      // dup2 onto an occupied slot replaces it, count unchanged
      send_request(CMD_DUP2, 10'($urandom), 6'd0, 6'd1);
      send_request(CMD_GET, 10'($urandom), 6'd1, 6'($urandom));
      send_request(CMD_CLOSE, 10'($urandom), 6'd2, 6'($urandom));
      // the freed slot is the lowest one, so install refills it
      send_request(CMD_INSTALL, 10'h2AA, 6'($urandom), 6'($urandom));
   endtask

   // Range and unused-slot errors on every command that takes a slot
   task automatic test_error_statuses();
      send_request(CMD_GET, 10'($urandom), 6'd63, 6'd0);
      send_request(CMD_CLOSE, 10'($urandom), 6'(SLOTS), 6'd0);
      send_request(CMD_CLOSE, 10'($urandom), 6'd5, 6'd0);
      send_request(CMD_DUP, 10'($urandom), 6'd7, 6'd0);
      send_request(CMD_DUP, 10'($urandom), 6'd63, 6'd0);
      // a bad destination wins over a good source
      send_request(CMD_DUP2, 10'($urandom), 6'd0, 6'd63);
      // a bad source index wins over an unused check
      send_request(CMD_DUP2, 10'($urandom), 6'(SLOTS), 6'd0);
      // source unused while the destination is in range
      send_request(CMD_DUP2, 10'($urandom), 6'd5, 6'd0);
      // get of an unused slot returns no descriptor
      send_request(CMD_GET, 10'd1023, 6'(SLOTS - 2), 6'd63);
   endtask

   task automatic test_reserved_commands();
      send_request(CMD_RSVD5, 10'd1023, 6'd63, 6'd63);
      send_request(CMD_RSVD6, 10'd0, 6'd0, 6'd0);
      send_request(CMD_RSVD7, 10'd1023, 6'd1, 6'd2);
   endtask

   // Fill the table, hit it with install, dup and dup2 while full, then empty it
   task automatic test_table_full();
      while (lowest_free_slot() < SLOTS) begin
         if ($urandom_range(0, 1))
            send_request(CMD_INSTALL, 10'($urandom), pick_slot(), pick_slot());
         else
            send_request(CMD_DUP, 10'($urandom), pick_slot(), pick_slot());
      end
      send_request(CMD_INSTALL, 10'($urandom), 6'($urandom), 6'($urandom));
      send_request(CMD_DUP, 10'($urandom), 6'd0, 6'($urandom));
      send_request(CMD_DUP2, 10'($urandom), 6'(SLOTS - 1), 6'd0);
      for (int i = SLOTS - 1; i >= 0; i--)
         send_request(CMD_CLOSE, 10'($urandom), 6'(i), 6'($urandom));
   endtask

   // Random traffic; the mode swings the table between empty and full
   task automatic test_random_traffic(input int count, input int idle_pct, input int stall);
      traffic_mode_type mode;
      int roll;
      logic [CMD_W-1:0] cmd;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      mode = MODE_MIXED;
      for (int n = 0; n < count; n++) begin
         if (n % 30 == 0) mode = traffic_mode_type'($urandom_range(0, 2));
         roll = $urandom_range(0, 99);
         case (mode)
            MODE_GROW:
               cmd = (roll < 40) ? CMD_INSTALL : (roll < 65) ? CMD_DUP :
                     (roll < 80) ? CMD_DUP2 : (roll < 90) ? CMD_GET :
                     (roll < 96) ? CMD_CLOSE : CMD_RSVD5;
            MODE_SHRINK:
               cmd = (roll < 45) ? CMD_CLOSE : (roll < 65) ? CMD_GET :
                     (roll < 75) ? CMD_DUP2 : (roll < 85) ? CMD_INSTALL :
                     (roll < 95) ? CMD_DUP : CMD_RSVD6;
            default:
               cmd = (roll < 20) ? CMD_INSTALL : (roll < 37) ? CMD_DUP :
                     (roll < 55) ? CMD_DUP2 : (roll < 75) ? CMD_GET :
                     (roll < 95) ? CMD_CLOSE : CMD_RSVD7;
         endcase
         send_request(cmd, 10'($urandom_range(0, 1023)), pick_slot(), pick_slot());
      end
   endtask

   // Drop valid and hold until every expected response has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      send_idle_pct = 0;
      stall_pct = 0;
      mismatch_count = 0;
      requests_sent = 0;
      responses_seen = 0;
      full_table_hits = 0;
      shadow_count = '0;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_value[i] = '0;
      end
      for (int i = 0; i < 4; i++) status_hits[i] = 0;
      for (int i = 0; i < 8; i++) command_hits[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_commands();
      test_error_statuses();
      test_reserved_commands();
      test_table_full();
      test_random_traffic(410, 0, 0);
      test_random_traffic(410, 72, 0);
      test_random_traffic(410, 0, 72);
      test_random_traffic(410, 21, 21);
      drain_responses();

      if (pending_responses.size() != 0) begin
         mismatch_count += pending_responses.size();
         $display("%0d expected responses never arrived", pending_responses.size());
      end
      $display("covered %0d requests (install %0d, dup %0d, dup2 %0d, get %0d, close %0d)",
               requests_sent, command_hits[CMD_INSTALL], command_hits[CMD_DUP],
               command_hits[CMD_DUP2], command_hits[CMD_GET], command_hits[CMD_CLOSE]);
      $display("statuses ok %0d, range %0d, unused %0d, full %0d; full-table hits %0d",
               status_hits[ST_OK], status_hits[ST_RANGE], status_hits[ST_UNUSED],
               status_hits[ST_FULL], full_table_hits);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
